/* hw/rtl/bkl_pkg.sv */
// Package for the bakery ticket lock arbiter.
// Holds action and status codes, controller states and the command and
// status structs between controller and datapath. Depends on nothing.
`timescale 1ns / 1ps

package bkl_pkg;

  // Request actions; the unused code behaves as a poll.
  localparam logic [1:0] ACT_ACQUIRE = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_POLL    = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_OVERFLOW = 2'd1;
  localparam logic [1:0] STS_RANGE    = 2'd2;

  // Widths fixed by the port list.
  localparam int ID_W    = 4;
  localparam int CNT_W   = 5;
  localparam int OUT_T_W = 16;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } bkl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the request and clear the scan results
    logic scan;    // read the next ticket slot
    logic finish;  // commit the ticket update and register the result
  } bkl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;    // the slot being read is the last one in use
  } bkl_sts_t;

endpackage

/* hw/rtl/bkl_ctrl.sv */
// Controller state machine for the bakery ticket lock arbiter.
// Sequences request capture, the ticket table scan and the final update.
// Depends on bkl_pkg.
`timescale 1ns / 1ps

module bkl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output bkl_pkg::bkl_cmd_t cmd,
  input  bkl_pkg::bkl_sts_t sts
);
  import bkl_pkg::*;

  bkl_state_t state_r;
  bkl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy       = 1'b1;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN:  cmd.scan = 1'b1;
      ST_DRAIN: ;
      ST_FIN:   cmd.finish = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

/* hw/rtl/bkl_dp.sv */
// Datapath for the bakery ticket lock arbiter.
// Holds the ticket table, the clients-in-use register, the scan for the
// largest ticket and the holder, and the result registers. Depends on bkl_pkg.
`timescale 1ns / 1ps

module bkl_dp #(
  parameter int CLIENTS     = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bkl_pkg::CNT_W-1:0]    cfg_data,
  input  logic [1:0]                   in_action,
  input  logic [bkl_pkg::ID_W-1:0]     in_client_id,
  input  bkl_pkg::bkl_cmd_t            cmd,
  output bkl_pkg::bkl_sts_t            sts,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic                         out_granted,
  output logic [bkl_pkg::OUT_T_W-1:0]  out_ticket,
  output logic                         out_owner_valid,
  output logic [bkl_pkg::ID_W-1:0]     out_owner_id
);
  import bkl_pkg::*;

  localparam int AW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  // The clients-in-use register cannot name more than 31 slots.
  localparam int NCAP = (CLIENTS > 31) ? 31 : CLIENTS;
  localparam logic [CNT_W-1:0] NCAP_W = NCAP[CNT_W-1:0];
  localparam logic [CNT_W-1:0] ONE_W  = CNT_W'(1);

  typedef logic [TICKET_BITS-1:0] ticket_t;

  // Ticket table with one valid bit per slot; an unwritten slot reads zero.
  ticket_t            mem [CLIENTS];
  logic [CLIENTS-1:0] vbits_r;

  logic [CNT_W-1:0] cfg_r;
  logic [1:0]       act_r;
  logic [CNT_W-1:0] id_r;
  logic [CNT_W-1:0] n_r;
  logic             inr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pv_r;
  logic [CNT_W-1:0] pidx_r;
  ticket_t          rd_data_r;
  logic             rd_vld_r;
  ticket_t          max_r;
  ticket_t          best_r;
  logic [CNT_W-1:0] own_r;
  logic             found_r;
  ticket_t          old_r;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] id_ext;
  ticket_t          rd_t;
  logic             ovf;
  logic             wr_en;
  ticket_t          t_new;
  logic [1:0]       status;
  logic             own_v;
  logic [CNT_W-1:0] own_f;

  // Clients-in-use register, clamped to the table size when used, zero as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 5'd16;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = ONE_W;
    end else if (cfg_r > NCAP_W) begin
      n_eff = NCAP_W;
    end else begin
      n_eff = cfg_r;
    end
  end

  assign id_ext = CNT_W'(in_client_id);

  // Request capture and scan counter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      id_r  <= id_ext;
      n_r   <= n_eff;
      inr_r <= (id_ext < n_eff);
      cnt_r <= '0;
    end else if (cmd.scan) begin
      cnt_r <= cnt_r + ONE_W;
    end
  end

  assign sts.last = (cnt_r == n_r - ONE_W);

  // Read port, addressed by the scan counter, with registered data.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data_r <= mem[AW'(cnt_r)];
      rd_vld_r  <= vbits_r[AW'(cnt_r)];
      pidx_r    <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.scan;
    end
  end

  assign rd_t = rd_vld_r ? rd_data_r : '0;

  // Running maximum over the slots in use, and the holder over them all but the
  // requester's own, whose old ticket is kept aside.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      max_r   <= '0;
      best_r  <= '0;
      own_r   <= '0;
      found_r <= 1'b0;
      old_r   <= '0;
    end else if (pv_r) begin
      if (rd_t > max_r) begin
        max_r <= rd_t;
      end
      if (pidx_r == id_r) begin
        old_r <= rd_t;
      end else if (rd_t != '0 && (!found_r || rd_t < best_r)) begin
        found_r <= 1'b1;
        best_r  <= rd_t;
        own_r   <= pidx_r;
      end
    end
  end

  // New ticket of the requester and the status of the request.
  always_comb begin
    ovf    = (max_r == '1);
    wr_en  = 1'b0;
    t_new  = old_r;
    status = STS_OK;
    if (!inr_r) begin
      t_new  = '0;
      status = STS_RANGE;
    end else begin
      case (act_r)
        ACT_ACQUIRE: begin
          if (ovf) begin
            status = STS_OVERFLOW;
          end else begin
            t_new = max_r + ticket_t'(1);
            wr_en = 1'b1;
          end
        end
        ACT_RELEASE: begin
          t_new = '0;
          wr_en = 1'b1;
        end
        default: t_new = old_r;
      endcase
    end
  end

  // Holder after the update: the best other slot, or the requester itself.
  always_comb begin
    own_v = 1'b0;
    own_f = '0;
    if (found_r && (t_new == '0 || best_r < t_new ||
                    (best_r == t_new && own_r < id_r))) begin
      own_v = 1'b1;
      own_f = own_r;
    end else if (t_new != '0) begin
      own_v = 1'b1;
      own_f = id_r;
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem[AW'(id_r)] <= t_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r <= '0;
    end else if (cmd.finish && wr_en) begin
      vbits_r[AW'(id_r)] <= 1'b1;
    end
  end

  // Result registers and strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status      <= status;
      out_granted     <= own_v && (t_new != '0) && (own_f == id_r);
      out_ticket      <= OUT_T_W'(t_new);
      out_owner_valid <= own_v;
      out_owner_id    <= ID_W'(own_f);
    end
  end

endmodule

/* hw/rtl/bakery_ticket_lock_arbiter_unit.sv */
// Top level of the bakery ticket lock arbiter.
// Joins the controller (bkl_ctrl) and the datapath (bkl_dp). Depends on bkl_pkg.
//
// Channel   Ports                                   Handshake
// request   in_action, in_client_id                 start high while busy low
// result    out_status, out_granted, out_ticket,     out_valid strobe, one cycle
//           out_owner_valid, out_owner_id
// config    cfg_data                                cfg_valid and cfg_ready
//
// A request is not accepted until the one before it is done: the scan reads
// one ticket slot per cycle from the single read port of the ticket table,
// over the clamped clients-in-use count, then come the drain and update states.
// The result strobe is registered from the update state.
// Reset clears all tickets at once through per-slot valid bits; no sweep.
// The receiver cannot stall the result; cfg_ready is always high.
`timescale 1ns / 1ps

module bakery_ticket_lock_arbiter_unit #(
  parameter int CLIENTS     = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [bkl_pkg::ID_W-1:0]     in_client_id,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic                         out_granted,
  output logic [bkl_pkg::OUT_T_W-1:0]  out_ticket,
  output logic                         out_owner_valid,
  output logic [bkl_pkg::ID_W-1:0]     out_owner_id,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bkl_pkg::CNT_W-1:0]    cfg_data
);
  import bkl_pkg::*;

  bkl_cmd_t cmd;
  bkl_sts_t sts;

  // The configuration register is always ready to take a write.
  assign cfg_ready = 1'b1;

  bkl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  bkl_dp #(
    .CLIENTS     (CLIENTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_client_id    (in_client_id),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_granted     (out_granted),
    .out_ticket      (out_ticket),
    .out_owner_valid (out_owner_valid),
    .out_owner_id    (out_owner_id)
  );

endmodule

/* bench/tb_bakery_ticket_lock_arbiter_unit.sv */
// Self-checking testbench for the bakery ticket lock arbiter.
// A ticket table predictor checks every result; directed and random request
// phases run under several clients-in-use settings. Depends on bkl_pkg.
`timescale 1ns / 1ps

module tb_bakery_ticket_lock_arbiter_unit;
  import bkl_pkg::*;

  localparam int          TB_CLIENTS  = 16;
  localparam logic [1:0]  ACT_SPARE   = 2'd3;   // unused code, behaves as a poll
  localparam logic [15:0] TICKET_TOP  = 16'hFFFF;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          REPORT_MAX  = 10;

  // One result of the block, in port order.
  typedef struct packed {
    logic [1:0]  status;
    logic        granted;
    logic [15:0] ticket;
    logic        owner_valid;
    logic [3:0]  owner_id;
  } lock_reply_t;

  // Predictor of the ticket table together with the store of expected replies.
  class ticket_lock_predictor;
    logic [15:0] ticket_of [TB_CLIENTS];
    logic [4:0]  clients_reg;
    lock_reply_t expected_replies [$];
    int          mismatches;

    function void clear_table();
      foreach (ticket_of[i]) ticket_of[i] = '0;
      clients_reg = 5'd16;
      mismatches  = 0;
    endfunction

    function void set_clients(logic [4:0] value);
      clients_reg = value;
    endfunction

    // Zero counts as one slot, anything above the table size as the full table.
    function int active_clients();
      if (clients_reg == 0) return 1;
      if (clients_reg > TB_CLIENTS) return TB_CLIENTS;
      return int'(clients_reg);
    endfunction

    function logic [15:0] largest_active();
      logic [15:0] top;
      top = '0;
      for (int i = 0; i < active_clients(); i++)
        if (ticket_of[i] > top) top = ticket_of[i];
      return top;
    endfunction

    function int backlog();
      return expected_replies.size();
    endfunction

    // Applies one accepted request to the table and stores the reply it causes.
    function void note_request(logic [1:0] act, logic [3:0] id);
      lock_reply_t reply;
      int          n;
      logic [15:0] top;
      logic        found;
      logic [15:0] best;
      logic [3:0]  holder;
      n     = active_clients();
      reply = '0;
      if (id >= n) begin
        reply.status = STS_RANGE;
      end else if (act == ACT_ACQUIRE) begin
        top = largest_active();
        if (top == TICKET_TOP) reply.status = STS_OVERFLOW;
        else ticket_of[id] = top + 16'd1;
      end else if (act == ACT_RELEASE) begin
        ticket_of[id] = '0;
      end
      // The lowest non-zero ticket holds the lock; a strict compare keeps the
      // lower client on a tie.
      found  = 1'b0;
      best   = '0;
      holder = '0;
      for (int i = 0; i < n; i++) begin
        if (ticket_of[i] != 0 && (!found || ticket_of[i] < best)) begin
          found  = 1'b1;
          best   = ticket_of[i];
          holder = i[3:0];
        end
      end
      reply.owner_valid = found;
      reply.owner_id    = holder;
      if (id < n) begin
        reply.ticket  = ticket_of[id];
        reply.granted = (ticket_of[id] != 0) && found && (holder == id);
      end
      expected_replies.push_back(reply);
    endfunction

    function void report(string what, lock_reply_t want, lock_reply_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display({"%0t: %s: expected sts=%0d gnt=%0d tkt=%0d own_v=%0d own=%0d, ",
                  "got sts=%0d gnt=%0d tkt=%0d own_v=%0d own=%0d"},
                 $time, what, want.status, want.granted, want.ticket,
                 want.owner_valid, want.owner_id, got.status, got.granted,
                 got.ticket, got.owner_valid, got.owner_id);
    endfunction

    // Compares a result with the oldest expected reply.
    function void check_result(lock_reply_t got);
      lock_reply_t want;
      if (expected_replies.size() == 0) begin
        report("result with no request outstanding", '0, got);
      end else begin
        want = expected_replies.pop_front();
        if (want.status !== got.status || want.granted !== got.granted ||
            want.ticket !== got.ticket || want.owner_valid !== got.owner_valid ||
            want.owner_id !== got.owner_id)
          report("result mismatch", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [1:0]  in_action    = ACT_POLL;
  logic [3:0]  in_client_id = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_granted;
  logic [15:0] out_ticket;
  logic        out_owner_valid;
  logic [3:0]  out_owner_id;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data     = '0;

  ticket_lock_predictor lock_table;
  bit                   sender_idles = 1'b1;
  int                   quiet_cycles = 0;

  bakery_ticket_lock_arbiter_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_client_id    (in_client_id),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_granted     (out_granted),
    .out_ticket      (out_ticket),
    .out_owner_valid (out_owner_valid),
    .out_owner_id    (out_owner_id),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      lock_table.check_result({out_status, out_granted, out_ticket, out_owner_valid,
                               out_owner_id});
  end

  // The watchdog ends the run after too long with no request, result or write.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly no gap or a short one, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    if (!sender_idles) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Issues one request and returns at the edge that accepts it. With no gap,
  // start stays high into the next request.
  task automatic send_request(input logic [1:0] act, input logic [3:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= act;
    in_client_id <= id;
    do @(posedge clk); while (busy);
    lock_table.note_request(act, id);
  endtask

  // Waits until every reply has arrived and the block has gone idle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (lock_table.backlog() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_clients(input logic [4:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lock_table.set_clients(value);
  endtask

  // Random requests: mostly acquires and releases from clients in use, with
  // polls, the spare action and clients outside the active range mixed in.
  task automatic random_requests(input int count);
    int         n;
    int         roll;
    logic [1:0] act;
    logic [3:0] id;
    for (int k = 0; k < count; k++) begin
      n    = lock_table.active_clients();
      roll = $urandom_range(0, 99);
      if (roll < 45) act = ACT_ACQUIRE;
      else if (roll < 75) act = ACT_RELEASE;
      else if (roll < 95) act = ACT_POLL;
      else act = ACT_SPARE;
      if ($urandom_range(0, 99) < 85) id = 4'($urandom_range(0, n - 1));
      else id = 4'($urandom_range(0, TB_CLIENTS - 1));
      send_request(act, id);
    end
  endtask

  initial begin
    logic [4:0] settings [10];
    lock_table = new;
    lock_table.clear_table();
    settings = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd2, 5'd9, 5'd17, 5'd1, 5'd0, 5'd16};
    settings[8] = 5'($urandom_range(0, 31));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, release while idle, and a ticket left in a slot
    // that later drops out of arbitration.
    send_request(ACT_POLL, 4'd0);
    send_request(ACT_RELEASE, 4'd3);
    send_request(ACT_ACQUIRE, 4'd12);
    write_clients(5'd4);
    send_request(ACT_ACQUIRE, 4'd9);
    send_request(ACT_POLL, 4'd12);
    send_request(ACT_ACQUIRE, 4'd1);
    // Back to the full table: clients 1 and 12 tie and the lower one wins.
    write_clients(5'd16);
    send_request(ACT_POLL, 4'd12);
    send_request(ACT_ACQUIRE, 4'd15);
    send_request(ACT_ACQUIRE, 4'd1);
    send_request(ACT_SPARE, 4'd12);
    send_request(ACT_RELEASE, 4'd12);
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_RELEASE, 4'd0);
    send_request(ACT_SPARE, 4'd3);
    // A count of zero acts as one, a count above the table as the full table.
    write_clients(5'd0);
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_POLL, 4'd1);
    send_request(ACT_RELEASE, 4'd0);
    write_clients(5'd31);
    send_request(ACT_POLL, 4'd1);
    send_request(ACT_ACQUIRE, 4'd15);

    // With one client in use, back-to-back acquires by that client each take
    // the next ticket, while the other slots keep theirs.
    write_clients(5'd1);
    sender_idles = 1'b0;
    repeat (8) send_request(ACT_ACQUIRE, 4'd0);
    sender_idles = 1'b1;
    send_request(ACT_POLL, 4'd0);
    write_clients(5'd16);
    send_request(ACT_ACQUIRE, 4'd5);
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_POLL, 4'd0);
    send_request(ACT_RELEASE, 4'd0);

    // Random phases, each under its own setting; some run with no gaps.
    foreach (settings[p]) begin
      write_clients(settings[p]);
      sender_idles = ($urandom_range(0, 3) != 0);
      random_requests(40);
    end
    sender_idles = 1'b1;

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (lock_table.mismatches == 0 && lock_table.backlog() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
